[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL of the butterfly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/fpr2b_pkg.sv]
package fpr2b_pkg;

    // Field widths.
    localparam int SAMPLE_W   = 22;
    localparam int SEL_W      = 5;
    localparam int TW_FRAC    = 14;
    localparam int TW_W       = TW_FRAC + 2;
    localparam int ACC_W      = SAMPLE_W + TW_W + 2;

    // Stream word widths.
    localparam int IN_TDATA_W  = 4 * SAMPLE_W;
    localparam int IN_TUSER_W  = SEL_W;
    localparam int OUT_TDATA_W = 4 * SAMPLE_W;

    // Twiddle table geometry: a quarter wave of cosine serves all 32 entries.
    localparam int ROM_ENTRIES = 32;
    localparam int QUARTER     = 16;
    localparam int QIDX_W      = 5;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [TW_W-1:0]     t_coef;

    typedef struct packed {
        t_sample          top_re;
        t_sample          top_im;
        t_sample          bottom_re;
        t_sample          bottom_im;
        logic [SEL_W-1:0] twiddle_sel;
    } t_bfly_in;

    typedef struct packed {
        t_sample sum_re;
        t_sample sum_im;
        t_sample diff_re;
        t_sample diff_im;
    } t_bfly_out;

    typedef struct packed {
        t_coef re;
        t_coef im;
    } t_twiddle;

    // round(cos(2*pi*i/64) * 2^14) for i = 0 .. 16.
    localparam t_coef COS_Q [0:QUARTER] = '{
        16'sd16384, 16'sd16305, 16'sd16069, 16'sd15679, 16'sd15137, 16'sd14449,
        16'sd13623, 16'sd12665, 16'sd11585, 16'sd10394, 16'sd9102,  16'sd7723,
        16'sd6270,  16'sd4756,  16'sd3196,  16'sd1606,  16'sd0
    };

    // W = cos - j*sin for angle 2*pi*k/64, both parts from the quarter wave.
    function automatic t_twiddle twiddle_lookup(input logic [SEL_W-1:0] sel);
        logic [QIDX_W-1:0] k;
        logic              first_q;
        logic [QIDX_W-1:0] idx_re;
        logic [QIDX_W-1:0] idx_im;
        t_twiddle          w;
        k       = sel;
        first_q = (k <= QIDX_W'(QUARTER));
        idx_re  = first_q ? k : QIDX_W'((QIDX_W + 1)'(ROM_ENTRIES) - {1'b0, k});
        idx_im  = first_q ? QIDX_W'(QUARTER) - k : k - QIDX_W'(QUARTER);
        w.re    = first_q ? COS_Q[idx_re] : -COS_Q[idx_re];
        w.im    = -COS_Q[idx_im];
        return w;
    endfunction

endpackage

[rtl/core/fixed_point_radix2_butterfly.sv]
// Channel   Direction  Word                                          Sideband
// s         in         tdata: top_re, top_im, bottom_re, bottom_im   tuser: twiddle_sel
// m         out        tdata: sum_re, sum_im, diff_re, diff_im       none
//
// One word is taken per clock while the input register is free or emptying. A taken word
// passes the input register, then the result register, from which its result leaves.
// The twiddle table read, complex multiply and rounding sit between the input and
// result registers.
// Reset is synchronous and active low; it empties both registers and nothing else.
// A stall on the output holds the result; the input register still takes a word while
// it is empty.
`include "assert_macros.svh"

module fixed_point_radix2_butterfly (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // top_re [21:0], top_im [43:22], bottom_re [65:44], bottom_im [87:66]
    input  logic [fpr2b_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // twiddle_sel [4:0]
    input  logic [fpr2b_pkg::IN_TUSER_W-1:0]   i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // sum_re [21:0], sum_im [43:22], diff_re [65:44], diff_im [87:66]
    output logic [fpr2b_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import fpr2b_pkg::*;

    logic      r_s1_valid;
    t_bfly_in  r_s1_item;
    logic      r_out_valid;
    t_bfly_out r_out;
    t_bfly_in  in_item;
    t_bfly_out n_out;
    logic      out_ready;
    logic      s1_ready;

    // Unpack the incoming word.
    always_comb begin
        in_item.top_re      = i_s_tdata[0*SAMPLE_W +: SAMPLE_W];
        in_item.top_im      = i_s_tdata[1*SAMPLE_W +: SAMPLE_W];
        in_item.bottom_re   = i_s_tdata[2*SAMPLE_W +: SAMPLE_W];
        in_item.bottom_im   = i_s_tdata[3*SAMPLE_W +: SAMPLE_W];
        in_item.twiddle_sel = i_s_tuser[SEL_W-1:0];
    end

    // Each register moves on when the one after it is free or emptying.
    assign out_ready  = !r_out_valid || i_m_tready;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign o_s_tready = s1_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_s_tvalid) begin
            r_s1_item <= in_item;
        end
    end

    // Butterfly arithmetic.
    fpr2b_calc u_calc (
        .i_item   (r_s1_item),
        .o_result (n_out)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    // Pack the outgoing word.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.diff_im, r_out.diff_re, r_out.sum_im, r_out.sum_re};

    // A full input register behind a stalled result must refuse new words.
    `ASSERT_CLK(a_no_take_when_full, (r_s1_valid && r_out_valid && !i_m_tready) |-> !o_s_tready, "input taken while both registers are blocked")
    // A word in the input register reaches the output once the output is free.
    `ASSERT_CLK(a_advance, (r_s1_valid && out_ready) |=> o_m_tvalid, "word lost between input and result registers")
    // Nothing appears at the output without a word before it.
    `ASSERT_CLK(a_no_invent, (!r_s1_valid && i_m_tready) |=> !o_m_tvalid, "result shown without a word behind it")
    // Reset empties the result register.
    `ASSERT_ALWAYS(a_reset_empty, !$past(i_rst_n) |-> !o_m_tvalid, "result valid right after reset")

endmodule

[rtl/core/fpr2b_calc.sv]
module fpr2b_calc (
    input  fpr2b_pkg::t_bfly_in  i_item,
    output fpr2b_pkg::t_bfly_out o_result
);
    import fpr2b_pkg::*;

    localparam logic [TW_FRAC-1:0] HALF   = TW_FRAC'(1) << (TW_FRAC - 1);
    localparam int                 PROD_W = SAMPLE_W + TW_W;

    t_twiddle                 w;
    logic signed [PROD_W-1:0] m_rr;
    logic signed [PROD_W-1:0] m_ii;
    logic signed [PROD_W-1:0] m_ri;
    logic signed [PROD_W-1:0] m_ir;
    logic signed [ACC_W-1:0]  p_re;
    logic signed [ACC_W-1:0]  p_im;
    logic signed [ACC_W-1:0]  s_re;
    logic signed [ACC_W-1:0]  s_im;

    // Round half to even on the fraction bits, then keep the low sample bits.
    function automatic t_sample round_wrap(input logic signed [ACC_W-1:0] v);
        logic [TW_FRAC-1:0]  frac;
        logic [SAMPLE_W-1:0] q;
        logic                up;
        frac = v[TW_FRAC-1:0];
        q    = v[TW_FRAC +: SAMPLE_W];
        up   = (frac > HALF) || ((frac == HALF) && q[0]);
        return t_sample'(q + SAMPLE_W'(up));
    endfunction

    // Twiddle from the constant table.
    assign w = twiddle_lookup(i_item.twiddle_sel);

    // Partial products, each at the full width of a sample times a coefficient.
    assign m_rr = i_item.bottom_re * w.re;
    assign m_ii = i_item.bottom_im * w.im;
    assign m_ri = i_item.bottom_re * w.im;
    assign m_ir = i_item.bottom_im * w.re;

    // Complex product bottom * W, exact at Q.14.
    assign p_re = ACC_W'(m_rr) - ACC_W'(m_ii);
    assign p_im = ACC_W'(m_ri) + ACC_W'(m_ir);

    // Top sample lifted to the same scale.
    assign s_re = ACC_W'(i_item.top_re) <<< TW_FRAC;
    assign s_im = ACC_W'(i_item.top_im) <<< TW_FRAC;

    // Sum and difference, each rounded and wrapped.
    always_comb begin
        o_result.sum_re  = round_wrap(s_re + p_re);
        o_result.sum_im  = round_wrap(s_im + p_im);
        o_result.diff_re = round_wrap(s_re - p_re);
        o_result.diff_im = round_wrap(s_im - p_im);
    end

endmodule

[bench/tb_top.sv]
module tb_top;

    import fpr2b_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_WORDS  = 650;
    localparam int DRAIN_CYCLES  = 10;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int IDLE_PERCENT  = 33;
    localparam int STEADY_FIRST  = 250;
    localparam int STEADY_LAST   = 400;

    // Quarter-wave cosine in Q2.14, index i gives round(cos(2*pi*i/64) * 2^14).
    localparam int QUARTER_IDX = 16;
    localparam int ROM_SIZE    = 32;
    localparam int QCOS [0:16] = '{
        16384, 16305, 16069, 15679, 15137, 14449, 13623, 12665,
        11585, 10394,  9102,  7723,  6270,  4756,  3196,  1606, 0
    };

    localparam longint HALF_LSB = longint'(1) <<< (TW_FRAC - 1);
    localparam longint FRAC_MSK = (longint'(1) <<< TW_FRAC) - 1;
    localparam longint WORD_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint WORD_MIN = -(longint'(1) <<< (SAMPLE_W - 1));
    localparam t_sample S_MAX   = t_sample'(WORD_MAX);
    localparam t_sample S_MIN   = t_sample'(WORD_MIN);

    // Twiddle indices that make the cosine and sine parts equal in size.
    localparam logic [SEL_W-1:0] SEL_EIGHTH  = SEL_W'(8);
    localparam logic [SEL_W-1:0] SEL_3EIGHTH = SEL_W'(24);

    // Predicts each butterfly and keeps the outstanding results in order.
    class butterfly_checker;
        t_bfly_out   awaited[$];
        int          errors;
        int          words_in;
        int          words_out;
        int          ties;
        int          wraps;
        logic [31:0] sel_seen;

        function new();
            errors    = 0;
            words_in  = 0;
            words_out = 0;
            ties      = 0;
            wraps     = 0;
            sel_seen  = '0;
        endfunction

        // Round a Q.14 value half to even, then wrap it to the sample width.
        function t_sample round_half_even(longint v);
            longint q;
            longint frac;
            q    = v >>> TW_FRAC;
            frac = v & FRAC_MSK;
            if (frac == HALF_LSB) begin
                ties++;
            end
            if (frac > HALF_LSB || (frac == HALF_LSB && q[0])) begin
                q = q + 1;
            end
            if (q > WORD_MAX || q < WORD_MIN) begin
                wraps++;
            end
            return t_sample'(q);
        endfunction

        // Form A + B*W and A - B*W exactly, then round each part.
        function t_bfly_out butterfly_of(t_bfly_in w);
            int        k;
            longint    wr;
            longint    wi;
            longint    br;
            longint    bi;
            longint    pr;
            longint    pim;
            longint    sr;
            longint    si;
            t_bfly_out r;
            k = int'(w.twiddle_sel);
            if (k <= QUARTER_IDX) begin
                wr = QCOS[k];
            end else begin
                wr = -QCOS[ROM_SIZE - k];
            end
            wi  = -QCOS[(k <= QUARTER_IDX) ? QUARTER_IDX - k : k - QUARTER_IDX];
            br  = w.bottom_re;
            bi  = w.bottom_im;
            pr  = br * wr - bi * wi;
            pim = br * wi + bi * wr;
            sr  = longint'(w.top_re) <<< TW_FRAC;
            si  = longint'(w.top_im) <<< TW_FRAC;
            r.sum_re  = round_half_even(sr + pr);
            r.sum_im  = round_half_even(si + pim);
            r.diff_re = round_half_even(sr - pr);
            r.diff_im = round_half_even(si - pim);
            return r;
        endfunction

        function void note_word(t_bfly_in w);
            awaited.push_back(butterfly_of(w));
            sel_seen[w.twiddle_sel] = 1'b1;
            words_in++;
        endfunction

        function void compare_part(string name, t_sample want, t_sample got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_bfly_out got);
            t_bfly_out want;
            words_out++;
            if (awaited.size() == 0) begin
                $error("result word with nothing outstanding: %h", got);
                errors++;
            end else begin
                want = awaited.pop_front();
                compare_part("sum_re",  want.sum_re,  got.sum_re);
                compare_part("sum_im",  want.sum_im,  got.sum_im);
                compare_part("diff_re", want.diff_re, got.diff_re);
                compare_part("diff_im", want.diff_im, got.diff_im);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   steady   = 1'b0;
    int                     cycles   = 0;

    butterfly_checker sb = new();

    fixed_point_radix2_butterfly u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: check each accepted word, then choose the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_word('{sum_re:  m_tdata[SAMPLE_W-1:0],
                            sum_im:  m_tdata[2*SAMPLE_W-1:SAMPLE_W],
                            diff_re: m_tdata[3*SAMPLE_W-1:2*SAMPLE_W],
                            diff_im: m_tdata[4*SAMPLE_W-1:3*SAMPLE_W]});
        end
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    function automatic t_bfly_in make_word(t_sample a_re, t_sample a_im,
                                           t_sample b_re, t_sample b_im,
                                           logic [SEL_W-1:0] k);
        t_bfly_in w;
        w.top_re      = a_re;
        w.top_im      = a_im;
        w.bottom_re   = b_re;
        w.bottom_im   = b_im;
        w.twiddle_sel = k;
        return w;
    endfunction

    // A sample drawn from the full range, the edges, or a small window around zero.
    function automatic t_sample pick_sample(int unsigned mode);
        t_sample v;
        case (mode)
            0: begin
                v = t_sample'($urandom);
            end
            1: begin
                case ($urandom_range(0, 4))
                    0: v = S_MAX;
                    1: v = S_MIN;
                    2: v = '0;
                    3: v = '1;
                    default: v = t_sample'(1);
                endcase
            end
            default: begin
                v = t_sample'(int'($urandom_range(0, 128)) - 64);
            end
        endcase
        return v;
    endfunction

    // Offer one word and hold it until the block takes it, with a random gap first.
    task automatic send_word(t_bfly_in w);
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PERCENT);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.bottom_im, w.bottom_re, w.top_im, w.top_re};
        s_tuser  <= w.twiddle_sel;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_word(w);
    endtask

    // Stimulus, drain and verdict.
    initial begin
        t_bfly_in    w;
        int unsigned mode;
        int          odd;
        t_sample     b_re;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Edges of the sample range, overflow that must wrap, and exact halves.
        send_word(make_word('0, '0, '0, '0, SEL_W'(0)));
        send_word(make_word(S_MAX, S_MAX, S_MAX, S_MAX, SEL_W'(0)));
        send_word(make_word(S_MIN, S_MIN, S_MIN, S_MIN, SEL_W'(0)));
        send_word(make_word(S_MAX, S_MIN, S_MIN, S_MAX, SEL_W'(4)));
        send_word(make_word(S_MAX, S_MAX, S_MIN, S_MIN, SEL_W'(16)));
        send_word(make_word(S_MIN, S_MIN, S_MAX, S_MAX, SEL_W'(31)));
        send_word(make_word(S_MAX, S_MAX, S_MAX, S_MAX, SEL_EIGHTH));
        send_word(make_word(S_MIN, S_MAX, S_MIN, S_MAX, SEL_3EIGHTH));
        send_word(make_word('1, '1, '1, '1, SEL_3EIGHTH));
        send_word(make_word('0, '0, t_sample'(8192), '0, SEL_EIGHTH));
        send_word(make_word(t_sample'(1), t_sample'(1), t_sample'(8192), '0, SEL_EIGHTH));
        send_word(make_word('1, '1, t_sample'(8192), '0, SEL_EIGHTH));
        send_word(make_word(t_sample'(2), t_sample'(-3), t_sample'(-8192), '0, SEL_3EIGHTH));
        send_word(make_word(t_sample'(12345), t_sample'(-6789), t_sample'(-1000),
                            t_sample'(77777), SEL_W'(17)));
        send_word(make_word(t_sample'(-54321), t_sample'(999), t_sample'(31),
                            t_sample'(-2048), SEL_W'(15)));
        send_word(make_word(t_sample'(1), t_sample'(-1), S_MAX, S_MIN, SEL_W'(28)));
        send_word(make_word(S_MIN, S_MAX, t_sample'(1), t_sample'(-1), SEL_W'(12)));

        // Random words, mostly full range, with edge, small and exact-half mixes.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady <= (n >= STEADY_FIRST && n < STEADY_LAST);
            mode = $urandom_range(0, 99);
            if (mode < 40) begin
                w = make_word(pick_sample(0), pick_sample(0), pick_sample(0),
                              pick_sample(0), SEL_W'($urandom));
            end else if (mode < 60) begin
                w = make_word(pick_sample($urandom_range(0, 1)),
                              pick_sample($urandom_range(0, 1)),
                              pick_sample($urandom_range(0, 1)),
                              pick_sample($urandom_range(0, 1)), SEL_W'($urandom));
            end else if (mode < 80) begin
                w = make_word(pick_sample(2), pick_sample(2), pick_sample(2),
                              pick_sample(2), SEL_W'($urandom));
            end else begin
                // Bottom parts summing to an odd multiple of 8192 land on a half.
                odd  = 2 * int'($urandom_range(0, 63)) - 63;
                b_re = pick_sample(2);
                w = make_word(pick_sample($urandom_range(0, 2)),
                              pick_sample($urandom_range(0, 2)), b_re,
                              t_sample'(8192 * odd - int'(b_re)),
                              $urandom_range(0, 1) ? SEL_EIGHTH : SEL_3EIGHTH);
            end
            send_word(w);
        end
        s_tvalid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words in, %0d results checked, %0d errors, twiddle indices hit: %h",
                 sb.words_in, sb.words_out, sb.errors, sb.sel_seen);
        $display("%0d parts rounded from an exact half, %0d parts wrapped past 22 bits",
                 sb.ties, sb.wraps);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
